/* rtl/date_countdown_to_segments_core_defines.svh */
// ----------------------------------------------------------------------------
// date countdown assertion macros
// shared concurrent assertion forms for the countdown core
// ----------------------------------------------------------------------------
`ifndef DATE_COUNTDOWN_TO_SEGMENTS_CORE_DEFINES_SVH
`define DATE_COUNTDOWN_TO_SEGMENTS_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define DCS_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("dcs assertion failed");

// next-cycle implication, disabled during reset
`define DCS_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("dcs assertion failed");

`endif

/* rtl/dcs_pkg.sv */
// ----------------------------------------------------------------------------
// dcs_pkg
// constants and helper functions for the date countdown core
// ----------------------------------------------------------------------------
package dcs_pkg;

    localparam logic [7:0] BASE_YEAR     = 8'd21;
    localparam logic [8:0] DAYS_PER_YEAR = 9'd365;

    localparam logic [7:0] SEG_0 = ~8'hFC;
    localparam logic [7:0] SEG_1 = ~8'h60;
    localparam logic [7:0] SEG_2 = ~8'hDA;
    localparam logic [7:0] SEG_3 = ~8'hF2;
    localparam logic [7:0] SEG_4 = ~8'h66;
    localparam logic [7:0] SEG_5 = ~8'hB6;
    localparam logic [7:0] SEG_6 = ~8'hBE;
    localparam logic [7:0] SEG_7 = ~8'hE0;
    localparam logic [7:0] SEG_8 = ~8'hFE;
    localparam logic [7:0] SEG_9 = ~8'hF6;
    localparam logic [7:0] SEG_BLANK = 8'hFF;

    // reciprocal constants for division by 10, 100 and 1000 of 16-bit values
    localparam logic [15:0] RECIP_10    = 16'd52429;
    localparam logic [16:0] RECIP_100   = 17'd83887;
    localparam logic [16:0] RECIP_1000  = 17'd67109;

    typedef logic [7:0]  bcd_t;
    typedef logic [16:0] day_count_t;

    function automatic logic [7:0] bcd_to_bin(input bcd_t b);
        return 8'({b[7:4], 3'b000}) + 8'({b[7:4], 1'b0}) + 8'(b[3:0]);
    endfunction

    // days before the first of the given month, month in 1..12
    function automatic logic [8:0] month_start(input logic [3:0] m);
        case (m)
            4'd1:    return 9'd0;
            4'd2:    return 9'd31;
            4'd3:    return 9'd59;
            4'd4:    return 9'd90;
            4'd5:    return 9'd120;
            4'd6:    return 9'd151;
            4'd7:    return 9'd181;
            4'd8:    return 9'd212;
            4'd9:    return 9'd243;
            4'd10:   return 9'd273;
            4'd11:   return 9'd304;
            4'd12:   return 9'd334;
            default: return 9'd0;
        endcase
    endfunction

    function automatic logic [7:0] seg_code(input logic [3:0] digit);
        case (digit)
            4'd0:    return SEG_0;
            4'd1:    return SEG_1;
            4'd2:    return SEG_2;
            4'd3:    return SEG_3;
            4'd4:    return SEG_4;
            4'd5:    return SEG_5;
            4'd6:    return SEG_6;
            4'd7:    return SEG_7;
            4'd8:    return SEG_8;
            4'd9:    return SEG_9;
            default: return SEG_BLANK;
        endcase
    endfunction

endpackage

/* rtl/date_countdown_to_segments_core.sv */
// ----------------------------------------------------------------------------
// date_countdown_to_segments_core
// Converts a BCD calendar date into the days remaining to a target day and
// drives inverted seven-segment codes for the low three decimal digits.
//
// s_ channel: one BCD date per transfer (day, month, two-digit year).
// m_ channel: one result per date: days_left plus three segment codes.
// cfg_we / cfg_wdata: writes target_day, counted from 2021-01-01.
// A date passes the input register, loaded by the transfer, then the day
// count and subtract stage, then the digit split and segment lookup stage,
// which drives m_tvalid.
// Throughput: one date per cycle while m_tready is high; the rate is set by the
// three-stage pipeline, each stage taking a new item when its successor moves.
// Bubbles collapse, so a stalled result still lets empty stages fill.
// When m_tready is low with every stage full, s_tready drops and all
// stages hold their contents.
// Reset clears all valid flags and sets target_day to 0.
// ----------------------------------------------------------------------------
`include "date_countdown_to_segments_core_defines.svh"

module date_countdown_to_segments_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // date_bcd, month_bcd, year_bcd
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata    // days_left, seg_units, seg_tens, seg_hundreds
);
    import dcs_pkg::*;

    logic [15:0] target_reg;

    logic        in_vld_reg;
    bcd_t        date_reg, month_reg, year_reg;
    logic        mid_vld_reg;
    logic [15:0] left_reg, left_next;
    logic        out_vld_reg;
    logic [39:0] out_data_reg, out_data_next;

    logic en_out, en_mid, en_in;

    logic [7:0]  day_bin, mon_bin, yr_off;
    logic [3:0]  mon_cl;
    logic [16:0] year_days;
    logic [6:0]  leap_days;
    day_count_t  day_sum, day_cnt;
    logic        dec_en;

    logic [31:0] prod10;
    logic [32:0] prod100, prod1000;
    logic [12:0] q10;
    logic [9:0]  q100;
    logic [6:0]  q1000;
    logic [3:0]  dig_u, dig_t, dig_h;

    assign en_out   = !out_vld_reg || m_tready;
    assign en_mid   = !mid_vld_reg || en_out;
    assign en_in    = !in_vld_reg || en_mid;
    assign s_tready = en_in;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = out_data_reg;

    // day count and clamped difference
    always_comb begin
        day_bin = bcd_to_bin(date_reg);
        mon_bin = bcd_to_bin(month_reg);
        yr_off  = bcd_to_bin(year_reg) - BASE_YEAR;
        if (mon_bin < 8'd1) begin
            mon_cl = 4'd1;
        end else if (mon_bin > 8'd12) begin
            mon_cl = 4'd12;
        end else begin
            mon_cl = mon_bin[3:0];
        end
        year_days = 17'(yr_off) * 17'(DAYS_PER_YEAR);
        leap_days = 7'((9'(yr_off) + 9'd3) >> 2);
        day_sum   = 17'(day_bin) + 17'(month_start(mon_cl)) + year_days + 17'(leap_days);
        dec_en    = ((mon_cl <= 4'd2) || (yr_off[1:0] != 2'd0)) && (day_sum != 17'd0);
        day_cnt   = day_sum - 17'(dec_en);
        if (day_cnt >= 17'(target_reg)) begin
            left_next = 16'd0;
        end else begin
            left_next = target_reg - day_cnt[15:0];
        end
    end

    // decimal digit split and segment lookup
    always_comb begin
        prod10   = 32'(left_reg) * 32'(RECIP_10);
        prod100  = 33'(left_reg) * 33'(RECIP_100);
        prod1000 = 33'(left_reg) * 33'(RECIP_1000);
        q10      = prod10[31:19];
        q100     = prod100[32:23];
        q1000    = prod1000[32:26];
        dig_u    = 4'(left_reg - 16'(q10) * 16'd10);
        dig_t    = 4'(q10 - 13'(q100) * 13'd10);
        dig_h    = 4'(q100 - 10'(q1000) * 10'd10);
        out_data_next = {seg_code(dig_h), seg_code(dig_t), seg_code(dig_u), left_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_reg <= 16'd0;
        end else if (cfg_we) begin
            target_reg <= cfg_wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg  <= 1'b0;
            mid_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end else begin
            if (en_in) begin
                in_vld_reg <= s_tvalid;
            end
            if (en_mid) begin
                mid_vld_reg <= in_vld_reg;
            end
            if (en_out) begin
                out_vld_reg <= mid_vld_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (en_in && s_tvalid) begin
            date_reg  <= s_tdata[7:0];
            month_reg <= s_tdata[15:8];
            year_reg  <= s_tdata[23:16];
        end
        if (en_mid && in_vld_reg) begin
            left_reg <= left_next;
        end
        if (en_out && mid_vld_reg) begin
            out_data_reg <= out_data_next;
        end
    end

    `DCS_ASSERT_NXT(a_in_load, aclk, aresetn, s_tvalid && s_tready, in_vld_reg)
    `DCS_ASSERT_NXT(a_mid_load, aclk, aresetn, in_vld_reg && en_mid, mid_vld_reg)
    `DCS_ASSERT_NXT(a_out_load, aclk, aresetn, mid_vld_reg && en_out, m_tvalid)
    `DCS_ASSERT_IMP(a_left_bound, aclk, aresetn, mid_vld_reg && !cfg_we,
                    left_reg <= target_reg)

endmodule

/* dv/date_countdown_to_segments_core_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// date_countdown_to_segments_core_tb
// Self-checking bench for the date countdown core. A directed table covers
// reset, target extremes, leap days, clamping and malformed BCD, then random
// phases with fresh target days stream mostly valid dates plus noise. Every
// result transfer is checked against the table's expected result or an in-bench day-count predictor.
// ----------------------------------------------------------------------------
module date_countdown_to_segments_core_tb;

    import dcs_pkg::*;

    localparam int LIMIT_CYCLES = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 115;
    localparam int STALL_CYCLES = 80;
    localparam int STALL_AFTER  = 250;

    typedef struct packed {
        logic [7:0] year_bcd;
        logic [7:0] month_bcd;
        logic [7:0] date_bcd;
    } date_in_t;

    typedef struct packed {
        logic [7:0]  seg_hundreds;
        logic [7:0]  seg_tens;
        logic [7:0]  seg_units;
        logic [15:0] days_left;
    } countdown_t;

    typedef struct packed {
        logic [15:0] target;
        date_in_t    dt;
        logic        typed;
        countdown_t  want;
    } row_t;

    localparam countdown_t NO_RESULT = '0;

    localparam int MONTH_OFFSET [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
    localparam logic [7:0] DIGIT_SEG [10] = '{SEG_0, SEG_1, SEG_2, SEG_3, SEG_4,
                                              SEG_5, SEG_6, SEG_7, SEG_8, SEG_9};

    localparam int N_DIRECTED = 21;
    localparam row_t DIRECTED [N_DIRECTED] = '{
        '{16'd0,     '{8'h21, 8'h01, 8'h01}, 1'b1, '{SEG_0, SEG_0, SEG_0, 16'd0}},
        '{16'd0,     '{8'hFF, 8'hFF, 8'hFF}, 1'b1, '{SEG_0, SEG_0, SEG_0, 16'd0}},
        '{16'd65535, '{8'h21, 8'h01, 8'h01}, 1'b1, '{SEG_5, SEG_3, SEG_5, 16'd65535}},
        '{16'd65535, '{8'h21, 8'h00, 8'h00}, 1'b1, '{SEG_5, SEG_3, SEG_5, 16'd65535}},
        '{16'd65535, '{8'h20, 8'h01, 8'h01}, 1'b1, '{SEG_0, SEG_0, SEG_0, 16'd0}},
        '{16'd65535, '{8'h99, 8'h12, 8'h31}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'hFF, 8'hFF, 8'hFF}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h24, 8'h02, 8'h29}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h24, 8'h03, 8'h01}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h23, 8'h03, 8'h01}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h22, 8'h00, 8'h15}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h22, 8'h13, 8'h15}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h22, 8'h1F, 8'h15}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h30, 8'h05, 8'h0A}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h30, 8'h05, 8'hAF}, 1'b0, NO_RESULT},
        '{16'd65535, '{8'h00, 8'h01, 8'h01}, 1'b0, NO_RESULT},
        '{16'd1000,  '{8'h21, 8'h01, 8'h01}, 1'b1, '{SEG_0, SEG_0, SEG_0, 16'd1000}},
        '{16'd1000,  '{8'h21, 8'h01, 8'h02}, 1'b1, '{SEG_9, SEG_9, SEG_9, 16'd999}},
        '{16'd12345, '{8'h21, 8'h01, 8'h01}, 1'b1, '{SEG_3, SEG_4, SEG_5, 16'd12345}},
        '{16'd1,     '{8'h21, 8'h01, 8'h01}, 1'b1, '{SEG_0, SEG_0, SEG_1, 16'd1}},
        '{16'd1,     '{8'h21, 8'h01, 8'h02}, 1'b1, '{SEG_0, SEG_0, SEG_0, 16'd0}}
    };

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // date_bcd, month_bcd, year_bcd
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;   // days_left, seg_units, seg_tens, seg_hundreds

    countdown_t  pending_countdowns [$];
    logic [15:0] target_now;
    logic        steady;
    int          n_errors;
    int          n_results;
    int          n_cycles;
    int          stall_left;
    logic        stall_done;

    date_countdown_to_segments_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    function automatic countdown_t predict_countdown(input date_in_t dt, input logic [15:0] tgt);
        int d;
        int m;
        int y;
        int cnt;
        int left;
        countdown_t res;
        d = int'(dt.date_bcd[7:4]) * 10 + int'(dt.date_bcd[3:0]);
        m = int'(dt.month_bcd[7:4]) * 10 + int'(dt.month_bcd[3:0]);
        y = (int'(dt.year_bcd[7:4]) * 10 + int'(dt.year_bcd[3:0]) - 21) & 255;
        if (m < 1) m = 1;
        if (m > 12) m = 12;
        cnt = d + MONTH_OFFSET[m - 1] + 365 * y + (y + 3) / 4;
        // drop one day, except from march on in a year whose offset from 2021 is a multiple of four
        if ((m <= 2 || (y & 3) != 0) && cnt > 0) cnt = cnt - 1;
        cnt = cnt & 32'h1FFFF;
        left = (cnt >= int'(tgt)) ? 0 : int'(tgt) - cnt;
        res.days_left    = 16'(left);
        res.seg_units    = DIGIT_SEG[left % 10];
        res.seg_tens     = DIGIT_SEG[(left / 10) % 10];
        res.seg_hundreds = DIGIT_SEG[(left / 100) % 10];
        return res;
    endfunction

    function automatic logic [7:0] to_bcd(input int v);
        return {4'(v / 10), 4'(v % 10)};
    endfunction

    function automatic date_in_t random_date();
        date_in_t dt;
        int pick;
        pick = $urandom_range(99);
        dt.date_bcd  = to_bcd($urandom_range(31, 1));
        dt.month_bcd = to_bcd($urandom_range(12, 1));
        dt.year_bcd  = to_bcd($urandom_range(99, 21));
        if (pick < 15) begin
            dt = date_in_t'($urandom);
        end else if (pick < 20) begin
            case ($urandom_range(2))
                0: dt.date_bcd  = 8'($urandom);
                1: dt.month_bcd = 8'($urandom);
                default: dt.year_bcd = 8'($urandom);
            endcase
        end
        return dt;
    endfunction

    task automatic wait_drained();
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (pending_countdowns.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_target(input logic [15:0] value);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(negedge aclk);
        cfg_we     <= 1'b0;
        target_now = value;
    endtask

    task automatic offer_date(input date_in_t dt, input logic typed, input countdown_t want);
        while (!steady && $urandom_range(99) < 20) begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
        end
        @(negedge aclk);
        s_tvalid <= 1'b1;
        s_tdata  <= dt;
        do @(posedge aclk); while (!s_tready);
        pending_countdowns.push_back(typed ? want : predict_countdown(dt, target_now));
    endtask

    // result side ready, with one long hold-off so the pipeline backs up
    always @(negedge aclk) begin
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!stall_done && n_results >= STALL_AFTER) begin
            stall_done = 1'b1;
            stall_left = STALL_CYCLES - 1;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= steady || ($urandom_range(99) >= 20);
        end
    end

    always @(posedge aclk) begin
        countdown_t got;
        countdown_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got       = countdown_t'(m_tdata);
            n_results = n_results + 1;
            if (pending_countdowns.size() == 0) begin
                $error("result transfer with nothing expected: %h", m_tdata);
                n_errors = n_errors + 1;
            end else begin
                want = pending_countdowns.pop_front();
                if (got.days_left !== want.days_left) begin
                    $error("days_left: expected %0d, got %0d", want.days_left, got.days_left);
                    n_errors = n_errors + 1;
                end
                if (got.seg_units !== want.seg_units) begin
                    $error("seg_units: expected %h, got %h", want.seg_units, got.seg_units);
                    n_errors = n_errors + 1;
                end
                if (got.seg_tens !== want.seg_tens) begin
                    $error("seg_tens: expected %h, got %h", want.seg_tens, got.seg_tens);
                    n_errors = n_errors + 1;
                end
                if (got.seg_hundreds !== want.seg_hundreds) begin
                    $error("seg_hundreds: expected %h, got %h",
                           want.seg_hundreds, got.seg_hundreds);
                    n_errors = n_errors + 1;
                end
            end
        end
    end

    always @(posedge aclk) begin
        n_cycles = n_cycles + 1;
        if (n_cycles > LIMIT_CYCLES) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial begin
        int pick;
        aclk       = 1'b0;
        aresetn    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        target_now = '0;
        steady     = 1'b0;
        n_errors   = 0;
        n_results  = 0;
        n_cycles   = 0;
        stall_left = 0;
        stall_done = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int i = 0; i < N_DIRECTED; i++) begin
            if (DIRECTED[i].target != target_now) begin
                wait_drained();
                write_target(DIRECTED[i].target);
            end
            offer_date(DIRECTED[i].dt, DIRECTED[i].typed, DIRECTED[i].want);
        end

        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            pick = $urandom_range(3);
            if (p == 0)
                write_target(16'hFFFF);
            else if (p == 1)
                write_target(16'h0000);
            else if (pick < 2)
                write_target(16'($urandom_range(30000)));
            else if (pick == 2)
                write_target(16'($urandom_range(1200)));
            else
                write_target(16'($urandom));
            steady = (p == 4);
            for (int k = 0; k < PHASE_ITEMS; k++)
                offer_date(random_date(), 1'b0, NO_RESULT);
            steady = 1'b0;
        end

        wait_drained();
        if (n_errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
